@@ hw/rtl/fpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fisheye projection package
// Shared widths, register indexes, pipeline depth and the CORDIC angle table.
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int RAY_W     = 24;
    localparam int PIX_W     = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_REGS  = 8;

    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STAGES   = 32;
    localparam int DIV_STAGES    = 21;
    localparam int ACC_W         = 34;

    // Input, square-sum, root, divide, CORDIC set-up, CORDIC, theta and polynomial stages.
    localparam int PIPE_DEPTH = 75 + CORDIC_STAGES;

    localparam logic [2:0] REG_FOCAL_X      = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y      = 3'd1;
    localparam logic [2:0] REG_CENTER_X     = 3'd2;
    localparam logic [2:0] REG_CENTER_Y     = 3'd3;
    localparam logic [2:0] REG_COEF_CUBIC   = 3'd4;
    localparam logic [2:0] REG_COEF_FIFTH   = 3'd5;
    localparam logic [2:0] REG_COEF_SEVENTH = 3'd6;
    localparam logic [2:0] REG_COEF_NINTH   = 3'd7;

    localparam logic [CFG_W-1:0]        FOCAL_RESET = 24'd128000;
    localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [23:0]             PI_Q22      = 24'd13176795;

    function automatic logic signed [ACC_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ACC_W-1:0] v;
        begin
            case (idx)
                5'd0:  v = 34'sd843314857;
                5'd1:  v = 34'sd497837829;
                5'd2:  v = 34'sd263043837;
                5'd3:  v = 34'sd133525159;
                5'd4:  v = 34'sd67021687;
                5'd5:  v = 34'sd33543516;
                5'd6:  v = 34'sd16775851;
                5'd7:  v = 34'sd8388437;
                5'd8:  v = 34'sd4194283;
                5'd9:  v = 34'sd2097149;
                5'd31: v = 34'sd0;
                default: v = 34'sd1 <<< (5'd30 - idx);
            endcase
            return v;
        end
    endfunction

endpackage

@@ hw/rtl/fpr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fisheye projection channels
// Ray input, pixel output and register write channels with valid and ready.
// ----------------------------------------------------------------------------
interface fpr_ray_if ();
    import fpr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [RAY_W-1:0] ray_x;
    logic signed [RAY_W-1:0] ray_y;
    logic signed [RAY_W-1:0] ray_z;
    modport source (output valid, output ray_x, output ray_y, output ray_z, input ready);
    modport sink   (input valid, input ray_x, input ray_y, input ray_z, output ready);
endinterface

interface fpr_pix_if ();
    import fpr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_u;
    logic signed [PIX_W-1:0] pixel_v;
    logic                    clipped;
    modport source (output valid, output pixel_u, output pixel_v, output clipped, input ready);
    modport sink   (input valid, input pixel_u, input pixel_v, input clipped, output ready);
endinterface

interface fpr_cfg_if ();
    import fpr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/fisheye_ray_projection_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fisheye ray projection core
// Projects a 3D ray to Q16.8 pixel coordinates with the odd-polynomial
// fisheye model, using a bitwise root, a long divider and a CORDIC pipeline.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  i_cfg    in         index (4 bits), data (24 bits)
//  i_ray    in         ray_x, ray_y, ray_z (24 bits signed)
//  o_pix    out        pixel_u, pixel_v (24 bits signed), clipped
//
// One beat enters per cycle unless the output stalls.
// The 32-stage root, 21-stage divider and CORDIC chain make up most of the pipeline.
// Reset is synchronous and empties the pipeline; register writes are always taken.
// When the output beat is not taken the whole pipeline holds.
// ----------------------------------------------------------------------------
module fisheye_ray_projection_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    fpr_cfg_if.sink   i_cfg,
    fpr_ray_if.sink   i_ray,
    fpr_pix_if.source o_pix
);
    import fpr_pkg::*;

    localparam int CW      = 36;
    localparam int POS_DV  = 55;
    localparam int POS_T   = 57 + CORDIC_STAGES;
    localparam int POS_OUT = PIPE_DEPTH - 1;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [46:0]        sqx;
        logic [46:0]        sqy;
    } t_in;

    typedef struct packed {
        logic [63:0]        rem;
        logic [63:0]        res;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic               axis;
    } t_sq;

    typedef struct packed {
        logic [31:0]        rem_u;
        logic [31:0]        rem_v;
        logic [20:0]        q_u;
        logic [20:0]        q_v;
        logic               neg_u;
        logic               neg_v;
        logic [31:0]        r8;
        logic signed [23:0] z;
        logic               axis;
    } t_dv;

    typedef struct packed {
        logic signed [CW-1:0]    cx;
        logic signed [CW-1:0]    cy;
        logic signed [ACC_W-1:0] acc;
        logic signed [21:0]      ratio_u;
        logic signed [21:0]      ratio_v;
        logic                    axis;
    } t_cd;

    typedef struct packed {
        logic [23:0]        th;
        logic [25:0]        t2;
        logic signed [21:0] ratio_u;
        logic signed [21:0] ratio_v;
        logic               axis;
    } t_side;

    logic [CFG_W-1:0]      r_cfg [CFG_REGS];
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  w_adv;

    t_in   r_in;
    t_sq   r_sq [SQRT_STAGES+1];
    t_dv   r_dv [DIV_STAGES+1];
    t_cd   r_cd [CORDIC_STAGES+1];
    t_side r_sd [17];

    logic [47:0]        r_th2;
    logic signed [50:0] r_m3;
    logic signed [27:0] r_h2;
    logic signed [54:0] r_m2;
    logic signed [30:0] r_h1;
    logic signed [57:0] r_m1;
    logic signed [34:0] r_h0;
    logic signed [45:0] r_m0_lo;
    logic signed [43:0] r_m0_hi;
    logic signed [37:0] r_hf;
    logic signed [44:0] r_d_lo;
    logic signed [43:0] r_d_hi;
    logic signed [39:0] r_d;
    logic signed [45:0] r_fu_lo, r_fv_lo;
    logic signed [44:0] r_fu_hi, r_fv_hi;
    logic signed [43:0] r_m8u, r_m8v;
    logic signed [44:0] r_pu_lo, r_pv_lo;
    logic signed [43:0] r_pu_hi, r_pv_hi;
    logic signed [44:0] r_pu, r_pv;
    logic signed [PIX_W-1:0] r_out_u, r_out_v;
    logic                    r_out_clip;

    assign w_adv       = !r_vld[POS_OUT] || o_pix.ready;
    assign i_ray.ready = w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                r_cfg[i] <= (i == int'(REG_FOCAL_X) || i == int'(REG_FOCAL_Y)) ?
                            FOCAL_RESET : '0;
            end
        end else if (i_cfg.valid && i_cfg.index < CFG_IDX_W'(CFG_REGS)) begin
            r_cfg[i_cfg.index[2:0]] <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_ray.valid};
        end
    end

    // Squares and square sum.
    logic signed [47:0] w_sqx, w_sqy;
    logic [47:0]        w_sum;
    assign w_sqx = i_ray.ray_x * i_ray.ray_x;
    assign w_sqy = i_ray.ray_y * i_ray.ray_y;
    assign w_sum = {1'b0, r_in.sqx} + {1'b0, r_in.sqy};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in.x   <= i_ray.ray_x;
            r_in.y   <= i_ray.ray_y;
            r_in.z   <= i_ray.ray_z;
            r_in.sqx <= w_sqx[46:0];
            r_in.sqy <= w_sqy[46:0];
            r_sq[0].rem  <= {w_sum, 16'd0};
            r_sq[0].res  <= '0;
            r_sq[0].x    <= r_in.x;
            r_sq[0].y    <= r_in.y;
            r_sq[0].z    <= r_in.z;
            r_sq[0].axis <= (r_in.x == '0) && (r_in.y == '0);
        end
    end

    // Bitwise square root, one result bit per stage.
    for (genvar gk = 0; gk < SQRT_STAGES; gk++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gk);
        logic [63:0] w_trial;
        t_sq         n_sq;
        assign w_trial = r_sq[gk].res + BIT;
        always_comb begin
            n_sq = r_sq[gk];
            if (r_sq[gk].rem >= w_trial) begin
                n_sq.rem = r_sq[gk].rem - w_trial;
                n_sq.res = (r_sq[gk].res >> 1) + BIT;
            end else begin
                n_sq.res = r_sq[gk].res >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq[gk+1] <= n_sq;
            end
        end
    end

    // Divider set-up: magnitudes scaled so that the quotient is Q20.
    logic [23:0] w_abs_x, w_abs_y;
    assign w_abs_x = r_sq[SQRT_STAGES].x[23] ? 24'(-r_sq[SQRT_STAGES].x) : r_sq[SQRT_STAGES].x;
    assign w_abs_y = r_sq[SQRT_STAGES].y[23] ? 24'(-r_sq[SQRT_STAGES].y) : r_sq[SQRT_STAGES].y;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv[0].rem_u <= {1'b0, w_abs_x, 7'd0};
            r_dv[0].rem_v <= {1'b0, w_abs_y, 7'd0};
            r_dv[0].q_u   <= '0;
            r_dv[0].q_v   <= '0;
            r_dv[0].neg_u <= r_sq[SQRT_STAGES].x[23];
            r_dv[0].neg_v <= r_sq[SQRT_STAGES].y[23];
            r_dv[0].r8    <= r_sq[SQRT_STAGES].res[31:0];
            r_dv[0].z     <= r_sq[SQRT_STAGES].z;
            r_dv[0].axis  <= r_sq[SQRT_STAGES].axis;
        end
    end

    // Restoring division, one quotient bit per stage for each lane.
    for (genvar gd = 0; gd < DIV_STAGES; gd++) begin : g_div
        logic [32:0] w_tu, w_tv;
        logic        w_geu, w_gev;
        t_dv         n_dv;
        assign w_tu  = {r_dv[gd].rem_u, 1'b0};
        assign w_tv  = {r_dv[gd].rem_v, 1'b0};
        assign w_geu = w_tu >= {1'b0, r_dv[gd].r8};
        assign w_gev = w_tv >= {1'b0, r_dv[gd].r8};
        always_comb begin
            n_dv       = r_dv[gd];
            n_dv.rem_u = w_geu ? 32'(w_tu - {1'b0, r_dv[gd].r8}) : w_tu[31:0];
            n_dv.rem_v = w_gev ? 32'(w_tv - {1'b0, r_dv[gd].r8}) : w_tv[31:0];
            n_dv.q_u   = {r_dv[gd].q_u[19:0], w_geu};
            n_dv.q_v   = {r_dv[gd].q_v[19:0], w_gev};
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[gd+1] <= n_dv;
            end
        end
    end

    // CORDIC set-up: a ray behind the lens starts a quarter turn on.
    logic signed [CW-1:0] w_z256, w_r8c;
    logic signed [21:0]   w_qu, w_qv;
    assign w_z256 = $signed({{4{r_dv[DIV_STAGES].z[23]}}, r_dv[DIV_STAGES].z, 8'd0});
    assign w_r8c  = $signed({4'd0, r_dv[DIV_STAGES].r8});
    assign w_qu   = $signed({1'b0, r_dv[DIV_STAGES].q_u});
    assign w_qv   = $signed({1'b0, r_dv[DIV_STAGES].q_v});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cd[0].ratio_u <= r_dv[DIV_STAGES].neg_u ? -w_qu : w_qu;
            r_cd[0].ratio_v <= r_dv[DIV_STAGES].neg_v ? -w_qv : w_qv;
            r_cd[0].axis    <= r_dv[DIV_STAGES].axis;
            if (r_dv[DIV_STAGES].z[23]) begin
                r_cd[0].cx  <= w_r8c;
                r_cd[0].cy  <= -w_z256;
                r_cd[0].acc <= HALF_PI_Q30;
            end else begin
                r_cd[0].cx  <= w_z256;
                r_cd[0].cy  <= w_r8c;
                r_cd[0].acc <= '0;
            end
        end
    end

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
        logic signed [CW-1:0]    w_cx, w_cy, w_dx, w_dy;
        logic signed [ACC_W-1:0] w_ang;
        t_cd                     n_cd;
        assign w_cx  = r_cd[gi].cx;
        assign w_cy  = r_cd[gi].cy;
        assign w_dx  = w_cy >>> gi;
        assign w_dy  = w_cx >>> gi;
        assign w_ang = atan_q30(5'(gi));
        always_comb begin
            n_cd = r_cd[gi];
            if (w_cy >= 0) begin
                n_cd.cx  = w_cx + w_dx;
                n_cd.cy  = w_cy - w_dy;
                n_cd.acc = r_cd[gi].acc + w_ang;
            end else begin
                n_cd.cx  = w_cx - w_dx;
                n_cd.cy  = w_cy + w_dy;
                n_cd.acc = r_cd[gi].acc - w_ang;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_cd[gi+1] <= n_cd;
            end
        end
    end

    // Theta, rounded to Q22 and clamped to the half turn.
    logic signed [ACC_W:0] w_thr;
    logic [23:0]           w_th;
    assign w_thr = (($signed(r_cd[CORDIC_STAGES].acc) + 35'sd128) >>> 8);
    always_comb begin
        if (w_thr < 0) begin
            w_th = '0;
        end else if (w_thr > $signed({11'd0, PI_Q22})) begin
            w_th = PI_Q22;
        end else begin
            w_th = w_thr[23:0];
        end
    end

    // Polynomial and pixel arithmetic.
    logic [47:0]        w_t2r;
    t_side              n_sd2;
    logic signed [26:0] w_t2s3, w_t2s5, w_t2s7, w_t2s9;
    logic signed [24:0] w_ths, w_fxs, w_fys;
    logic signed [51:0] w_m3r;
    logic signed [54:0] w_m2r;
    logic signed [57:0] w_m1r;
    logic signed [59:0] w_m0r;
    logic signed [61:0] w_dr;
    logic signed [63:0] w_m8ur, w_m8vr, w_pur, w_pvr;

    assign w_t2r = r_th2 + 48'd2097152;
    always_comb begin
        n_sd2    = r_sd[1];
        n_sd2.t2 = w_t2r[47:22];
    end

    assign w_t2s3 = $signed({1'b0, r_sd[2].t2});
    assign w_t2s5 = $signed({1'b0, r_sd[4].t2});
    assign w_t2s7 = $signed({1'b0, r_sd[6].t2});
    assign w_t2s9 = $signed({1'b0, r_sd[8].t2});
    assign w_ths  = $signed({1'b0, r_sd[10].th});
    assign w_fxs  = $signed({1'b0, r_cfg[REG_FOCAL_X]});
    assign w_fys  = $signed({1'b0, r_cfg[REG_FOCAL_Y]});

    assign w_m3r  = 52'(r_m3) + 52'sd2097152;
    assign w_m2r  = r_m2 + 55'sd2097152;
    assign w_m1r  = r_m1 + 58'sd2097152;
    assign w_m0r  = (60'(r_m0_hi) <<< 18) + 60'(r_m0_lo) + 60'sd2097152;
    assign w_dr   = (62'(r_d_hi) <<< 19) + 62'(r_d_lo) + 62'sd2097152;
    assign w_m8ur = (64'(r_fu_hi) <<< 20) + 64'(r_fu_lo) + 64'sd524288;
    assign w_m8vr = (64'(r_fv_hi) <<< 20) + 64'(r_fv_lo) + 64'sd524288;
    assign w_pur  = (64'(r_pu_hi) <<< 22) + 64'(r_pu_lo) + 64'sd524288;
    assign w_pvr  = (64'(r_pv_hi) <<< 22) + 64'(r_pv_lo) + 64'sd524288;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd[0].th      <= w_th;
            r_sd[0].t2      <= '0;
            r_sd[0].ratio_u <= r_cd[CORDIC_STAGES].ratio_u;
            r_sd[0].ratio_v <= r_cd[CORDIC_STAGES].ratio_v;
            r_sd[0].axis    <= r_cd[CORDIC_STAGES].axis;
            r_sd[1]         <= r_sd[0];
            r_sd[2]         <= n_sd2;
            for (int j = 3; j < 17; j++) begin
                r_sd[j] <= r_sd[j-1];
            end

            r_th2   <= r_sd[0].th * r_sd[0].th;
            r_m3    <= $signed(r_cfg[REG_COEF_NINTH]) * w_t2s3;
            r_h2    <= $signed(w_m3r[49:22]) + 28'($signed(r_cfg[REG_COEF_SEVENTH]));
            r_m2    <= r_h2 * w_t2s5;
            r_h1    <= $signed(w_m2r[52:22]) + 31'($signed(r_cfg[REG_COEF_FIFTH]));
            r_m1    <= r_h1 * w_t2s7;
            r_h0    <= $signed(w_m1r[56:22]) + 35'($signed(r_cfg[REG_COEF_CUBIC]));
            r_m0_lo <= $signed({1'b0, r_h0[17:0]}) * w_t2s9;
            r_m0_hi <= $signed(r_h0[34:18]) * w_t2s9;
            r_hf    <= $signed(w_m0r[59:22]) + 38'sd1048576;
            r_d_lo  <= $signed({1'b0, r_hf[18:0]}) * w_ths;
            r_d_hi  <= $signed(r_hf[37:19]) * w_ths;
            r_d     <= $signed(w_dr[61:22]);
            r_fu_lo <= $signed({1'b0, r_d[19:0]}) * w_fxs;
            r_fu_hi <= $signed(r_d[39:20]) * w_fxs;
            r_fv_lo <= $signed({1'b0, r_d[19:0]}) * w_fys;
            r_fv_hi <= $signed(r_d[39:20]) * w_fys;
            r_m8u   <= $signed(w_m8ur[63:20]);
            r_m8v   <= $signed(w_m8vr[63:20]);
            r_pu_lo <= $signed({1'b0, r_m8u[21:0]}) * r_sd[14].ratio_u;
            r_pu_hi <= $signed(r_m8u[43:22]) * r_sd[14].ratio_u;
            r_pv_lo <= $signed({1'b0, r_m8v[21:0]}) * r_sd[14].ratio_v;
            r_pv_hi <= $signed(r_m8v[43:22]) * r_sd[14].ratio_v;
            r_pu    <= 45'($signed(w_pur[63:20])) + 45'($signed(r_cfg[REG_CENTER_X]));
            r_pv    <= 45'($signed(w_pvr[63:20])) + 45'($signed(r_cfg[REG_CENTER_Y]));
        end
    end

    // Saturation and the on-axis case.
    logic                    w_hi_u, w_lo_u, w_hi_v, w_lo_v;
    logic signed [PIX_W-1:0] n_out_u, n_out_v;
    logic                    n_out_clip;

    assign w_hi_u = r_pu > 45'sd8388607;
    assign w_lo_u = r_pu < -45'sd8388608;
    assign w_hi_v = r_pv > 45'sd8388607;
    assign w_lo_v = r_pv < -45'sd8388608;

    always_comb begin
        if (r_sd[16].axis) begin
            n_out_u    = $signed(r_cfg[REG_CENTER_X]);
            n_out_v    = $signed(r_cfg[REG_CENTER_Y]);
            n_out_clip = 1'b0;
        end else begin
            n_out_u    = w_hi_u ? 24'sd8388607 : (w_lo_u ? -24'sd8388608 : r_pu[23:0]);
            n_out_v    = w_hi_v ? 24'sd8388607 : (w_lo_v ? -24'sd8388608 : r_pv[23:0]);
            n_out_clip = w_hi_u || w_lo_u || w_hi_v || w_lo_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_u    <= n_out_u;
            r_out_v    <= n_out_v;
            r_out_clip <= n_out_clip;
        end
    end

    assign o_pix.valid   = r_vld[POS_OUT];
    assign o_pix.pixel_u = r_out_u;
    assign o_pix.pixel_v = r_out_v;
    assign o_pix.clipped = r_out_clip;

`ifndef NO_ASSERTIONS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |=> $stable(r_vld))
        else $error("pipeline moved while the output beat was held");

    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.clipped) |->
        (o_pix.pixel_u == 24'sd8388607 || o_pix.pixel_u == -24'sd8388608 ||
         o_pix.pixel_v == 24'sd8388607 || o_pix.pixel_v == -24'sd8388608))
        else $error("clipped flag without a saturated coordinate");

    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SQRT_STAGES] |=> (r_sq[SQRT_STAGES].res[63:32] == '0))
        else $error("square root exceeds 32 bits");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[POS_DV] && !r_dv[DIV_STAGES].axis) |->
        (r_dv[DIV_STAGES].rem_u < r_dv[DIV_STAGES].r8 &&
         r_dv[DIV_STAGES].rem_v < r_dv[DIV_STAGES].r8))
        else $error("divider remainder not below divisor");

    a_theta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[POS_T] |-> (r_sd[0].th <= PI_Q22))
        else $error("theta above half turn");
`endif

endmodule
